FILE: hw/rtl/best_fit_chunk_allocator_macros.svh
// Assertion macros for the best-fit chunk allocator checker.
// No dependencies.
`ifndef BEST_FIT_CHUNK_ALLOCATOR_MACROS_SVH
`define BEST_FIT_CHUNK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, reset masked.
`define BFCA_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, reset masked.
`define BFCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/bfca_pkg.sv
// Shared types and codes for the best-fit chunk allocator.
// No dependencies.
package bfca_pkg;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_DEALLOC = 2'd1;
  localparam logic [1:0] FUNC_DEFRAG  = 2'd2;

  typedef struct packed {
    logic        is_free;
    logic [7:0]  id;
    logic [15:0] size;
  } entry_t;

  localparam int unsigned EntryBits = $bits(entry_t);

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] req_size;
    logic [7:0]  free_id;
  } req_t;

  typedef struct packed {
    logic       failed;
    logic [7:0] got_id;
  } rsp_t;

endpackage

FILE: hw/rtl/best_fit_chunk_allocator.sv
// Best-fit chunk allocator: one request at a time over a RAM-held chunk table.
// Allocate, deallocate and defragment pass over the N chunks (deallocate ends early
// on an id match); a split then shifts the chunks above the best fit; size zero,
// func 3 and bad ids skip the scan. The RAM port pair sets the pace.
// Reset: async active low; after reset the init state writes the initial chunk.
// Depends on bfca_pkg and bfca_ctl.
module best_fit_chunk_allocator #(
  parameter int unsigned HEAP_BYTES = 32768,
  parameter int unsigned MAX_CHUNKS = 64,
  parameter int unsigned MAX_ID     = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] req_size_i,
  input  logic [7:0]  free_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        failed_o,
  output logic [7:0]  got_id_o
);
  import bfca_pkg::*;

  logic ready, done, start;
  req_t req;
  rsp_t rsp;
  logic out_valid_q;
  rsp_t out_q;

  assign in_stall_o = !(ready && !out_valid_q);
  assign start = in_valid_i && !in_stall_o;
  assign req = '{func: func_i, req_size: req_size_i, free_id: free_id_i};

  bfca_ctl #(.HEAP_BYTES(HEAP_BYTES), .MAX_CHUNKS(MAX_CHUNKS), .MAX_ID(MAX_ID)) u_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .req_i  (req),
    .ready_o(ready),
    .done_o (done),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign failed_o    = out_q.failed;
  assign got_id_o    = out_q.got_id;

endmodule

FILE: hw/rtl/bfca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/bfca_ctl.sv
// Sequencer for the chunk table: scan, shift, split, free and compaction passes.
// Depends on bfca_pkg and bfca_ram.
module bfca_ctl #(
  parameter int unsigned HEAP_BYTES = 32768,
  parameter int unsigned MAX_CHUNKS = 64,
  parameter int unsigned MAX_ID     = 255
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bfca_pkg::req_t req_i,
  output logic          ready_o,
  output logic          done_o,
  output bfca_pkg::rsp_t rsp_o
);
  import bfca_pkg::*;

  localparam int unsigned IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_SCAN, ST_SHIFT, ST_SPLIT_A, ST_SPLIT_B, ST_DEFRAG, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] n_q, n_d, rd_q, rd_d, keep_q, keep_d;
  logic [7:0] newest_q, newest_d;
  req_t req_q, req_d;
  logic rv_q, rv_d;
  logic [IW-1:0] ri_q, ri_d;
  logic found_q, found_d;
  logic [IW-1:0] best_q, best_d;
  logic [15:0] bsize_q, bsize_d;
  logic [7:0] bid_q, bid_d;
  logic hv_q, hv_d;
  logic [IW-1:0] hidx_q, hidx_d;
  logic [7:0] hid_q, hid_d;
  logic [15:0] hsize_q, hsize_d;
  rsp_t rsp_q, rsp_d;

  logic we;
  logic [IW-1:0] waddr;
  entry_t wdata, rdata;
  logic [EntryBits-1:0] rdata_raw;

  assign rdata = entry_t'(rdata_raw);

  bfca_ram #(.Width(EntryBits), .Depth(MAX_CHUNKS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_q[IW-1:0]),
    .rdata_o(rdata_raw)
  );

  always_comb begin
    state_d = state_q; n_d = n_q; rd_d = rd_q; keep_d = keep_q; newest_d = newest_q;
    req_d = req_q; rv_d = 1'b0; ri_d = ri_q; found_d = found_q; best_d = best_q;
    bsize_d = bsize_q; bid_d = bid_q; hv_d = hv_q; hidx_d = hidx_q; hid_d = hid_q;
    hsize_d = hsize_q; rsp_d = rsp_q;
    we = 1'b0; waddr = '0; wdata = '0;
    unique case (state_q)
      ST_INIT: begin
        we = 1'b1;
        wdata = '{is_free: 1'b1, id: 8'd0, size: 16'(HEAP_BYTES)};
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        rd_d = '0; keep_d = '0; found_d = 1'b0; hv_d = 1'b0;
        rsp_d = '{failed: 1'b0, got_id: 8'd0};
        if (start_i) begin
          req_d = req_i;
          priority if (req_i.func == FUNC_ALLOC && req_i.req_size == 16'd0) begin
            state_d = ST_DONE;
          end else if (req_i.func == FUNC_ALLOC) begin
            state_d = ST_SCAN;
          end else if (req_i.func == FUNC_DEALLOC) begin
            if (req_i.free_id > newest_q) begin
              rsp_d.failed = 1'b1;
              state_d = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end else if (req_i.func == FUNC_DEFRAG) begin
            state_d = ST_DEFRAG;
          end else begin
            rsp_d.failed = 1'b1;
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (rd_q < n_q) begin
          rv_d = 1'b1; ri_d = rd_q[IW-1:0]; rd_d = rd_q + CW'(1);
        end
        if (rv_q) begin
          if (req_q.func == FUNC_ALLOC) begin
            if (rdata.is_free && rdata.size >= req_q.req_size &&
                (!found_q || rdata.size < bsize_q)) begin
              found_d = 1'b1; best_d = ri_q; bsize_d = rdata.size; bid_d = rdata.id;
            end
          end else if (rdata.id == req_q.free_id) begin
            we = 1'b1; waddr = ri_q; wdata = rdata; wdata.is_free = 1'b1;
            rv_d = 1'b0;
            state_d = ST_DONE;
          end
        end else if (rd_q == n_q) begin
          if (req_q.func != FUNC_ALLOC) begin
            state_d = ST_DONE;
          end else if (!found_q) begin
            rsp_d.failed = 1'b1; state_d = ST_DONE;
          end else if (bsize_q == req_q.req_size) begin
            we = 1'b1; waddr = best_q;
            wdata = '{is_free: 1'b0, id: bid_q, size: bsize_q};
            rsp_d.got_id = bid_q; state_d = ST_DONE;
          end else if (n_q >= CW'(MAX_CHUNKS) || newest_q >= 8'(MAX_ID)) begin
            rsp_d.failed = 1'b1; state_d = ST_DONE;
          end else begin
            rd_d = n_q - CW'(1);
            state_d = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (rd_q > CW'(best_q)) begin
          rv_d = 1'b1; ri_d = rd_q[IW-1:0]; rd_d = rd_q - CW'(1);
        end
        if (rv_q) begin
          we = 1'b1; waddr = ri_q + IW'(1); wdata = rdata;
        end else if (rd_q == CW'(best_q)) begin
          state_d = ST_SPLIT_A;
        end
      end
      ST_SPLIT_A: begin
        we = 1'b1; waddr = best_q;
        wdata = '{is_free: 1'b1, id: bid_q, size: bsize_q - req_q.req_size};
        state_d = ST_SPLIT_B;
      end
      ST_SPLIT_B: begin
        we = 1'b1; waddr = best_q + IW'(1);
        wdata = '{is_free: 1'b0, id: newest_q + 8'd1, size: req_q.req_size};
        newest_d = newest_q + 8'd1;
        n_d = n_q + CW'(1);
        rsp_d.got_id = newest_q + 8'd1;
        state_d = ST_DONE;
      end
      ST_DEFRAG: begin
        if (rd_q < n_q) begin
          rv_d = 1'b1; ri_d = rd_q[IW-1:0]; rd_d = rd_q + CW'(1);
        end
        if (rv_q) begin
          if (rdata.is_free && hv_q) begin
            hsize_d = hsize_q + rdata.size;
          end else if (rdata.is_free) begin
            hv_d = 1'b1; hidx_d = keep_q[IW-1:0]; hid_d = rdata.id; hsize_d = rdata.size;
            keep_d = keep_q + CW'(1);
          end else begin
            we = 1'b1; waddr = keep_q[IW-1:0]; wdata = rdata;
            keep_d = keep_q + CW'(1);
          end
        end else if (rd_q == n_q) begin
          n_d = keep_q;
          if (hv_q) begin
            we = 1'b1; waddr = hidx_q;
            wdata = '{is_free: 1'b1, id: hid_q, size: hsize_q};
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT; n_q <= CW'(1); newest_q <= 8'd0; rv_q <= 1'b0;
      rd_q <= '0; keep_q <= '0; found_q <= 1'b0; hv_q <= 1'b0;
    end else begin
      state_q <= state_d; n_q <= n_d; newest_q <= newest_d; rv_q <= rv_d;
      rd_q <= rd_d; keep_q <= keep_d; found_q <= found_d; hv_q <= hv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; ri_q <= ri_d; best_q <= best_d; bsize_q <= bsize_d; bid_q <= bid_d;
    hidx_q <= hidx_d; hid_q <= hid_d; hsize_q <= hsize_d; rsp_q <= rsp_d;
  end

  assign ready_o = (state_q == ST_IDLE);
  assign done_o  = (state_q == ST_DONE);
  assign rsp_o   = rsp_q;

endmodule

FILE: hw/rtl/bfca_checker.sv
// Port-level checker for the best-fit chunk allocator, bound to the top level.
// Depends on best_fit_chunk_allocator_macros.svh.
`include "best_fit_chunk_allocator_macros.svh"

module bfca_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       failed_o,
  input logic [7:0] got_id_o
);

  `BFCA_ASSERT(a_fail_zero_id, clk_i, rst_ni, out_valid_o && failed_o, got_id_o == 8'd0)
  `BFCA_ASSERT(a_no_accept_pending, clk_i, rst_ni, in_valid_i && !in_stall_o, !out_valid_o)
  `BFCA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `BFCA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(got_id_o) && $stable(failed_o))

endmodule

bind best_fit_chunk_allocator bfca_checker u_bfca_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .failed_o   (failed_o),
  .got_id_o   (got_id_o)
);
